// ----- design/exhaustive_pair_line_fit_defines.svh -----
// Assertion helpers for the top-level design file.
`ifndef EXHAUSTIVE_PAIR_LINE_FIT_DEFINES_SVH
`define EXHAUSTIVE_PAIR_LINE_FIT_DEFINES_SVH

// same-cycle implication
`define EPL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/epl_pkg.sv -----
package epl_pkg;

    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int N_W        = IDX_W + 1;
    localparam int CNT_W      = 6;
    localparam int MASK_W     = 32;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_SPACING   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_RD, ST_DIFF, ST_SPACE, ST_CLASS, ST_DIV, ST_CMUL,
        ST_CFIN, ST_NORM, ST_SUM, ST_LIM, ST_LAUNCH, ST_NEXT, ST_DRAIN, ST_DONE
    } state_t;

    // line hypothesis travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [17:0] c;
        logic [63:0]        lim;
        logic [CNT_W-1:0]   cnt;
        logic [MASK_W-1:0]  mask;
    } token_t;

    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [17:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } div_rsp_t;

endpackage

// ----- design/epl_div.sv -----
module epl_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  epl_pkg::div_req_t req,
    output epl_pkg::div_rsp_t rsp
);
    import epl_pkg::*;

    localparam logic [5:0] STEPS = 6'd33;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] num_reg, num_next;
    logic [17:0] den_reg, den_next;
    logic [17:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [18:0] sh;
    logic        ge;

    always_comb begin
        sh = {rem_reg, num_reg[32]};
        ge = sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[31:0], 1'b0};
            quo_next = {quo_reg[31:0], ge};
            rem_next = ge ? 18'(sh - {1'b0, den_reg}) : sh[17:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- design/epl_cell.sv -----
module epl_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [epl_pkg::IDX_W-1:0] cell_idx,
    input  logic [epl_pkg::N_W-1:0]   n_loaded,
    input  logic                      load_en,
    input  logic [epl_pkg::IDX_W-1:0] load_idx,
    input  logic signed [15:0]        load_x,
    input  logic signed [15:0]        load_y,
    input  epl_pkg::token_t           tok_in,
    output epl_pkg::token_t           tok_out
);
    import epl_pkg::*;

    logic signed [15:0] px_reg, py_reg;
    token_t             s1_tok_reg, s2_tok_reg, s3_tok_reg, out_tok_reg;
    token_t             out_tok_next;
    logic signed [32:0] pa_reg, pb_reg;
    logic [31:0]        ar_reg;
    logic               ov2_reg, ov3_reg;
    logic [63:0]        sq_reg;
    logic signed [34:0] r;
    logic [34:0]        r_abs;
    logic               active, hit;

    always_ff @(posedge aclk) begin
        if (load_en && load_idx == cell_idx) begin
            px_reg <= load_x;
            py_reg <= load_y;
        end
    end

    always_comb begin
        r = {{2{pa_reg[32]}}, pa_reg} + {{2{pb_reg[32]}}, pb_reg}
            + {{3{s1_tok_reg.c[17]}}, s1_tok_reg.c, 14'b0};
        r_abs  = r[34] ? 35'(-r) : 35'(r);
        active = {1'b0, cell_idx} < n_loaded;
        hit    = active && !ov3_reg && (sq_reg < s3_tok_reg.lim);
        out_tok_next = s3_tok_reg;
        if (hit) begin
            out_tok_next.cnt  = s3_tok_reg.cnt + CNT_W'(1);
            out_tok_next.mask = s3_tok_reg.mask | (MASK_W'(1) << cell_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tok_reg.valid  <= 1'b0;
            s2_tok_reg.valid  <= 1'b0;
            s3_tok_reg.valid  <= 1'b0;
            out_tok_reg.valid <= 1'b0;
        end else begin
            s1_tok_reg  <= tok_in;
            s2_tok_reg  <= s1_tok_reg;
            s3_tok_reg  <= s2_tok_reg;
            out_tok_reg <= out_tok_next;
        end
        pa_reg  <= tok_in.a * px_reg;
        pb_reg  <= tok_in.b * py_reg;
        ar_reg  <= r_abs[31:0];
        ov2_reg <= |r_abs[34:32];
        sq_reg  <= ar_reg * ar_reg;
        ov3_reg <= ov2_reg;
    end

    assign tok_out = out_tok_reg;

endmodule

// ----- design/exhaustive_pair_line_fit.sv -----
// Loading: one point per cycle while idle; the point with tlast starts the fit.
// Per pair: a sloped line goes through the bit-serial divider, a vertical or
// horizontal line skips it, and a pair under the spacing limit launches no line.
// The result follows once every pair is done and the 32-cell scoring chain,
// 4 stages per cell, has drained.
// Reset clears control, loads register defaults; point storage is not cleared.
`include "exhaustive_pair_line_fit_defines.svh"

module exhaustive_pair_line_fit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    // inliers[5:0], inlier_mask[37:6], coef_a[54:38], coef_b[71:55],
    // coef_c[89:72], zero fill [95:90]
    output logic [95:0] m_tdata,
    output logic        m_tuser    // found
);
    import epl_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]       thr_reg, spc_reg;
    logic [31:0]       t2_reg, s2_reg;
    logic [N_W-1:0]    n_reg;
    logic [IDX_W-1:0]  i_reg, j_reg;
    logic [31:0]       mem [MAX_POINTS];
    logic [31:0]       pi_reg, pj_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [32:0]       dxx_reg, dyy_reg;
    logic              neg_reg, steep_reg;
    logic signed [16:0] a_reg, b_reg, k_reg;
    logic signed [17:0] c_reg;
    logic signed [32:0] prod_reg;
    logic [30:0]       aa_reg, bb_reg;
    logic [31:0]       norm_reg;
    logic [63:0]       lim_reg;
    logic [7:0]        outst_reg;
    logic [CNT_W-1:0]  best_cnt_reg;
    logic [MASK_W-1:0] best_mask_reg;
    logic signed [16:0] best_a_reg, best_b_reg;
    logic signed [17:0] best_c_reg;
    logic              m_valid_reg;
    logic [95:0]       m_data_reg;
    logic              m_user_reg;

    logic              accept, store, launch, out_free;
    logic signed [15:0] xi, yi, xj, yj;
    logic signed [16:0] dx, dy;
    logic [16:0]       adx, ady, dnum, dden;
    logic [33:0]       d2;
    logic              skip, need_div, steep;
    logic [N_W:0]      j_inc, i_inc2;
    logic signed [16:0] k;
    logic [32:0]       pmag;
    logic [33:0]       rnd;
    logic signed [17:0] sr, cbase;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    token_t            tok [MAX_POINTS+1];

    always_comb begin
        xi  = pi_reg[15:0];
        yi  = pi_reg[31:16];
        xj  = pj_reg[15:0];
        yj  = pj_reg[31:16];
        dx  = 17'(xi) - 17'(xj);
        dy  = 17'(yi) - 17'(yj);
        adx = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
        ady = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
        d2  = {1'b0, dxx_reg} + {1'b0, dyy_reg};
        skip  = d2 < {2'b0, s2_reg};
        steep = !({1'b0, ady} < {adx, 1'b0});
        need_div = !skip && dx_reg != '0 && dy_reg != '0;
        dnum = steep ? adx : ady;
        dden = steep ? ady : adx;
        div_req.num   = {1'b0, dnum, 15'b0} + {16'b0, dden};
        div_req.den   = {dden, 1'b0};
        div_req.start = (state_reg == ST_CLASS) && need_div;
        k = neg_reg ? 17'(-{1'b0, div_rsp.quo[15:0]}) : {1'b0, div_rsp.quo[15:0]};
        pmag  = prod_reg[32] ? 33'(-prod_reg) : 33'(prod_reg);
        rnd   = {1'b0, pmag} + 34'd8192;
        sr    = prod_reg[32] ? 18'(-{1'b0, rnd[30:14]}) : {1'b0, rnd[30:14]};
        cbase = steep_reg ? 18'(xi) : 18'(yi);
        j_inc  = {2'b0, j_reg} + (N_W+1)'(1);
        i_inc2 = {2'b0, i_reg} + (N_W+1)'(2);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && s_tlast) state_next = ST_START;
            ST_START:  state_next = (n_reg < N_W'(2)) ? ST_DRAIN : ST_RD;
            ST_RD:     state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SPACE;
            ST_SPACE:  state_next = ST_CLASS;
            ST_CLASS:  state_next = skip ? ST_NEXT : (need_div ? ST_DIV : ST_NORM);
            ST_DIV:    if (div_rsp.done) state_next = ST_CMUL;
            ST_CMUL:   state_next = ST_CFIN;
            ST_CFIN:   state_next = ST_NORM;
            ST_NORM:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_LIM;
            ST_LIM:    state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_NEXT;
            ST_NEXT: begin
                if (j_inc < {1'b0, n_reg} || i_inc2 < {1'b0, n_reg}) state_next = ST_RD;
                else state_next = ST_DRAIN;
            end
            ST_DRAIN:  if (outst_reg == '0) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        launch   = (state_reg == ST_LAUNCH);
    end

    assign accept   = s_tvalid && s_tready;
    assign store    = accept && (n_reg < N_W'(MAX_POINTS));
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= 16'd102;
            spc_reg     <= 16'd0;
            n_reg       <= '0;
            outst_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_THRESHOLD: thr_reg <= cfg_wdata;
                    REG_SPACING:   spc_reg <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (store) n_reg <= n_reg + N_W'(1);
            if (launch && !tok[MAX_POINTS].valid) outst_reg <= outst_reg + 8'd1;
            else if (!launch && tok[MAX_POINTS].valid) outst_reg <= outst_reg - 8'd1;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                n_reg       <= '0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // point memory, two registered read ports
    always_ff @(posedge aclk) begin
        if (store) mem[n_reg[IDX_W-1:0]] <= s_tdata;
        if (state_reg == ST_RD) begin
            pi_reg <= mem[i_reg];
            pj_reg <= mem[j_reg];
        end
    end

    // hypothesis datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_START: begin
                t2_reg <= thr_reg * thr_reg;
                s2_reg <= spc_reg * spc_reg;
                i_reg  <= '0;
                j_reg  <= IDX_W'(1);
            end
            ST_DIFF: begin
                dx_reg <= dx;
                dy_reg <= dy;
            end
            ST_SPACE: begin
                dxx_reg <= 33'(dx_reg * dx_reg);
                dyy_reg <= 33'(dy_reg * dy_reg);
            end
            ST_CLASS: begin
                neg_reg   <= dx_reg[16] != dy_reg[16];
                steep_reg <= steep;
                if (dx_reg == '0) begin
                    a_reg <= -17'sd16384;
                    b_reg <= '0;
                    c_reg <= 18'(xi);
                end else begin
                    a_reg <= '0;
                    b_reg <= -17'sd16384;
                    c_reg <= 18'(yi);
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    k_reg <= k;
                    a_reg <= steep_reg ? -17'sd16384 : k;
                    b_reg <= steep_reg ? k : -17'sd16384;
                end
            end
            ST_CMUL: prod_reg <= k_reg * (steep_reg ? yi : xi);
            ST_CFIN: c_reg    <= cbase - sr;
            ST_NORM: begin
                aa_reg <= 31'(a_reg * a_reg);
                bb_reg <= 31'(b_reg * b_reg);
            end
            ST_SUM:  norm_reg <= {1'b0, aa_reg} + {1'b0, bb_reg};
            ST_LIM:  lim_reg  <= t2_reg * norm_reg;
            ST_NEXT: begin
                if (j_inc < {1'b0, n_reg}) begin
                    j_reg <= j_inc[IDX_W-1:0];
                end else begin
                    i_reg <= i_reg + IDX_W'(1);
                    j_reg <= i_inc2[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // best line, updated in launch order at the chain tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_cnt_reg <= '0;
        end else if (state_reg == ST_START) begin
            best_cnt_reg <= '0;
        end else if (tok[MAX_POINTS].valid && tok[MAX_POINTS].cnt > best_cnt_reg) begin
            best_cnt_reg <= tok[MAX_POINTS].cnt;
        end
        if (state_reg == ST_START) begin
            best_mask_reg <= '0;
            best_a_reg    <= '0;
            best_b_reg    <= '0;
            best_c_reg    <= '0;
        end else if (tok[MAX_POINTS].valid && tok[MAX_POINTS].cnt > best_cnt_reg) begin
            best_mask_reg <= tok[MAX_POINTS].mask;
            best_a_reg    <= tok[MAX_POINTS].a;
            best_b_reg    <= tok[MAX_POINTS].b;
            best_c_reg    <= tok[MAX_POINTS].c;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_user_reg <= best_cnt_reg != '0;
            m_data_reg <= {6'b0, best_c_reg, best_b_reg, best_a_reg,
                           best_mask_reg, best_cnt_reg};
        end
    end

    epl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        tok[0].valid = launch;
        tok[0].a     = a_reg;
        tok[0].b     = b_reg;
        tok[0].c     = c_reg;
        tok[0].lim   = lim_reg;
        tok[0].cnt   = '0;
        tok[0].mask  = '0;
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        epl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .n_loaded (n_reg),
            .load_en  (store),
            .load_idx (n_reg[IDX_W-1:0]),
            .load_x   (s_tdata[15:0]),
            .load_y   (s_tdata[31:16]),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `EPL_ASSERT_IMPL(a_tail_outstanding, aclk, aresetn,
        tok[MAX_POINTS].valid, outst_reg != '0,
        "hypothesis left the chain without a launch")
    `EPL_ASSERT_IMPL(a_done_in_div, aclk, aresetn,
        div_rsp.done, state_reg == ST_DIV,
        "divider finished outside the divide step")
    `EPL_ASSERT_IMPL(a_done_drained, aclk, aresetn,
        state_reg == ST_DONE, outst_reg == '0 && !tok[MAX_POINTS].valid,
        "result taken before chain drained")
    `EPL_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        state_reg == ST_DONE && out_free, m_valid_reg && n_reg == '0,
        "result not loaded at end of fit")

endmodule

// ----- tb/tb_exhaustive_pair_line_fit.sv -----
`timescale 1ns / 100ps

module tb_exhaustive_pair_line_fit;
    import epl_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        bit               found;
        bit [5:0]         cnt;
        bit [31:0]        mask;
        bit signed [16:0] a;
        bit signed [16:0] b;
        bit signed [17:0] c;
    } line_fit_t;

    class fit_scoreboard;
        shortint   pt_x[MAX_POINTS];
        shortint   pt_y[MAX_POINTS];
        int        n_loaded;
        bit [15:0] thr;
        bit [15:0] spc;
        line_fit_t expected_fits[$];
        int        errors;

        function new();
            n_loaded = 0;
            thr = 16'd102;
            spc = 16'd0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, bit [15:0] v);
            if (idx == REG_THRESHOLD) thr = v;
            else spc = v;
        endfunction

        // num/den to nearest, ties away from zero
        function longint round_div(longint num, longint den);
            bit     neg;
            longint n, d, q;
            neg = (num < 0) != (den < 0);
            n = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            q = (2 * n + d) / (2 * d);
            return neg ? -q : q;
        endfunction

        function line_fit_t compute_fit();
            line_fit_t best;
            longint    xi, yi, dx, dy, adx, ady, a, b, c, r, d2, s2;
            bit [63:0] norm2, lim, ar, t2;
            bit [31:0] mask;
            int        cnt, best_cnt;
            best = '{default: 0};
            best_cnt = 0;
            s2 = longint'(spc) * longint'(spc);
            t2 = 64'(thr) * 64'(thr);
            for (int i = 0; i + 1 < n_loaded; i++) begin
                for (int j = i + 1; j < n_loaded; j++) begin
                    xi = pt_x[i];
                    yi = pt_y[i];
                    dx = xi - pt_x[j];
                    dy = yi - pt_y[j];
                    d2 = dx * dx + dy * dy;
                    if (d2 < s2) continue;
                    adx = dx < 0 ? -dx : dx;
                    ady = dy < 0 ? -dy : dy;
                    if (dx == 0) begin
                        a = -16384; b = 0; c = xi;
                    end else if (dy == 0) begin
                        a = 0; b = -16384; c = yi;
                    end else if (ady < 2 * adx) begin
                        a = round_div(dy * 16384, dx);
                        b = -16384;
                        c = yi - round_div(a * xi, 16384);
                    end else begin
                        a = -16384;
                        b = round_div(dx * 16384, dy);
                        c = xi - round_div(b * yi, 16384);
                    end
                    norm2 = 64'(a * a + b * b);
                    lim = t2 * norm2;
                    cnt = 0;
                    mask = '0;
                    for (int m = 0; m < n_loaded; m++) begin
                        r = a * pt_x[m] + b * pt_y[m] + c * 16384;
                        ar = 64'(r < 0 ? -r : r);
                        if (ar < 64'h1_0000_0000 && ar * ar < lim) begin
                            cnt++;
                            mask[m] = 1'b1;
                        end
                    end
                    if (cnt > best_cnt) begin
                        best_cnt = cnt;
                        best.mask = mask;
                        best.a = 17'(a);
                        best.b = 17'(b);
                        best.c = 18'(c);
                    end
                end
            end
            best.found = best_cnt > 0;
            best.cnt = best_cnt > 63 ? 6'd63 : 6'(best_cnt);
            return best;
        endfunction

        function void note_point(logic [31:0] data, logic last);
            if (n_loaded < MAX_POINTS) begin
                pt_x[n_loaded] = data[15:0];
                pt_y[n_loaded] = data[31:16];
                n_loaded++;
            end
            if (last) begin
                expected_fits.insert(expected_fits.size(), compute_fit());
                n_loaded = 0;
            end
        endfunction

        function void check_result(logic [95:0] data, logic user);
            line_fit_t e;
            if (expected_fits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer: %h", data);
                return;
            end
            e = expected_fits.pop_front();
            if (user !== e.found || data[5:0] !== e.cnt || data[37:6] !== e.mask ||
                data[54:38] !== e.a || data[71:55] !== e.b || data[89:72] !== e.c) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp found=%0d cnt=%0d mask=%h a=%0d b=%0d c=%0d",
                              " got found=%0d cnt=%0d mask=%h a=%0d b=%0d c=%0d"},
                             e.found, e.cnt, e.mask, e.a, e.b, e.c,
                             user, data[5:0], data[37:6], $signed(data[54:38]),
                             $signed(data[71:55]), $signed(data[89:72]));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;

    exhaustive_pair_line_fit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fit_scoreboard board = new();
    bit      hold_req = 0;
    bit      no_gaps = 0;
    int      idle_cycles = 0;
    int      points_sent = 0;
    int      large_sets = 0;
    shortint set_x[$];
    shortint set_y[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic shortint clamp16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return shortint'(v);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_req = 0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_point(shortint x, shortint y, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {y, x};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        board.note_point({y, x}, last);
        points_sent++;
        @(negedge aclk);
    endtask

    task automatic send_set();
        for (int k = 0; k < set_x.size(); k++)
            send_point(set_x[k], set_y[k], k == set_x.size() - 1);
        set_x.delete();
        set_y.delete();
    endtask

    task automatic add(int x, int y);
        set_x.insert(set_x.size(), clamp16(x));
        set_y.insert(set_y.size(), clamp16(y));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_fits.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic set_regs(bit [15:0] t, bit [15:0] s);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_index <= REG_SPACING;
        cfg_wdata <= s;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_reg(REG_THRESHOLD, t);
        board.set_reg(REG_SPACING, s);
    endtask

    task automatic make_random_set();
        int kind, n, x0, y0, ux, uy, noise;
        kind = $urandom_range(0, 99);
        if (kind < 2 && large_sets < 3) begin
            // full set, once past the store depth
            large_sets++;
            n = large_sets == 2 ? 35 : 32;
            x0 = $signed($urandom_range(0, 40000)) - 20000;
            y0 = $signed($urandom_range(0, 40000)) - 20000;
            for (int k = 0; k < n; k++)
                add(x0 + k * 300 + $urandom_range(0, 50),
                    y0 + k * 100 + $urandom_range(0, 50));
        end else if (kind < 65) begin
            n = $urandom_range(2, 8);
            x0 = $signed($urandom_range(0, 50000)) - 25000;
            y0 = $signed($urandom_range(0, 50000)) - 25000;
            ux = $signed($urandom_range(0, 6000)) - 3000;
            uy = $signed($urandom_range(0, 6000)) - 3000;
            if ($urandom_range(0, 7) == 0) ux = 0;
            if ($urandom_range(0, 7) == 0) uy = 0;
            noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 5) == 0)
                    add($signed($urandom_range(0, 65535)) - 32768,
                        $signed($urandom_range(0, 65535)) - 32768);
                else
                    add(x0 + k * ux + $signed($urandom_range(0, 2 * noise)) - noise,
                        y0 + k * uy + $signed($urandom_range(0, 2 * noise)) - noise);
            end
        end else if (kind < 85) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                add($signed($urandom_range(0, 65535)) - 32768,
                    $signed($urandom_range(0, 65535)) - 32768);
        end else begin
            // repeated points
            n = $urandom_range(2, 6);
            x0 = $signed($urandom_range(0, 65535)) - 32768;
            y0 = $signed($urandom_range(0, 65535)) - 32768;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 1)) add(x0, y0);
                else add(x0 + $urandom_range(0, 30), y0);
            end
        end
    endtask

    initial begin
        bit [15:0] thr_list[7];
        bit [15:0] spc_list[7];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed sets on reset register values
        add(100, 200); send_set();                         // single point
        add(-32768, -32768); add(32767, 32767); send_set();
        add(-32768, 32767); add(32767, -32768); add(0, 0); send_set();
        add(500, -3000); add(500, 4000); add(520, 100); send_set();  // vertical
        add(-7000, 900); add(8000, 900); add(0, 950); send_set();    // horizontal
        add(1234, -4321); add(1234, -4321); send_set();              // coincident
        add(0, 0); add(100, 1000); add(200, 2000); add(5000, 0); send_set();
        add(-2000, 10); add(2000, 1000); add(0, 505); send_set();
        wait_drained();

        thr_list = '{0, 65535, 300, 1, 2000, 16'($urandom), 102};
        spc_list = '{0, 65535, 500, 0, 3000, 16'($urandom_range(0, 4000)), 65535};
        for (int ph = 0; ph < 7; ph++) begin
            set_regs(thr_list[ph], spc_list[ph]);
            no_gaps = ph == 3;
            if (ph == 2) hold_req = 1;
            while (points_sent < 40 + (ph + 1) * 165) begin
                make_random_set();
                send_set();
            end
            wait_drained();
        end

        if (board.errors == 0 && board.expected_fits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
